// ----- hw/rtl/lmrs_pkg.sv -----
// shared types, constants and command scripts for the led matrix refresh sequencer
`default_nettype none

package lmrs_pkg;

  // default sizes of the driver chip
  localparam int unsigned DEF_NUM_BANKS     = 11;
  localparam int unsigned DEF_NUM_CHANNELS  = 198;
  localparam int unsigned DEF_USED_CHANNELS = 195;

  localparam int unsigned CH_PER_BANK = 18;
  localparam int unsigned BANK_W      = 4;
  localparam int unsigned STEP_W      = 5;

  // input kinds
  localparam logic [2:0] K_TICK    = 3'd0;
  localparam logic [2:0] K_PIXEL   = 3'd1;
  localparam logic [2:0] K_BRIGHT  = 3'd2;
  localparam logic [2:0] K_PWR_ON  = 3'd3;
  localparam logic [2:0] K_PWR_OFF = 3'd4;

  // bus operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_BURST  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  // driver registers and values
  localparam logic [7:0] REG_UNLOCK  = 8'hfe;
  localparam logic [7:0] UNLOCK_KEY  = 8'hc5;
  localparam logic [7:0] REG_PAGE    = 8'hfd;
  localparam logic [7:0] PAGE_PWM    = 8'h00;
  localparam logic [7:0] PAGE_SCALE  = 8'h01;
  localparam logic [7:0] PAGE_FUNC   = 8'h02;
  localparam logic [7:0] REG_RESET   = 8'h2f;
  localparam logic [7:0] RESET_KEY   = 8'hae;
  localparam logic [7:0] REG_CFG     = 8'h00;
  localparam logic [7:0] CFG_INIT    = 8'h08;
  localparam logic [7:0] CFG_RUN     = 8'h09;
  localparam logic [7:0] REG_GCC     = 8'h01;
  localparam logic [7:0] GCC_OFF     = 8'h00;
  localparam logic [7:0] GCC_FULL    = 8'hff;
  localparam logic [7:0] REG_PULL    = 8'h02;
  localparam logic [7:0] PULL_VAL    = 8'h33;
  localparam logic [7:0] REG_SPREAD  = 8'h25;
  localparam logic [7:0] SPREAD_VAL  = 8'h00;
  localparam logic [7:0] SCALE_FULL  = 8'hff;

  localparam logic [31:0] WAIT_POWER_MS = 32'd20;
  localparam logic [31:0] WAIT_RESET_MS = 32'd2;

  // pending batch check
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_BATCH = 2'd1;
  localparam logic [1:0] PEND_READ  = 2'd2;

  typedef enum logic [7:0] {
    ST_OFF    = 8'b0000_0001,
    ST_WAIT   = 8'b0000_0010,
    ST_RESET  = 8'b0000_0100,
    ST_CONFIG = 8'b0000_1000,
    ST_PWM    = 8'b0001_0000,
    ST_SCALE  = 8'b0010_0000,
    ST_ENABLE = 8'b0100_0000,
    ST_READY  = 8'b1000_0000
  } stage_t;

  typedef enum logic [2:0] {
    JOB_STATUS = 3'd0,
    JOB_PIXEL  = 3'd1,
    JOB_RESET  = 3'd2,
    JOB_CONFIG = 3'd3,
    JOB_ENABLE = 3'd4,
    JOB_BANK   = 3'd5
  } job_kind_t;

  typedef struct packed {
    logic power_enable;
    logic ready_res;
    logic faulted;
  } status_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [BANK_W-1:0] bank;
    logic              scale;
    logic [7:0]        bright;
    logic [7:0]        ch;
    logic [7:0]        val;
    status_t           st;
  } job_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] addr;
    logic [7:0] data;
    logic       burst_end;
    status_t    st;
    logic       last;
  } res_t;

  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } dirty_fb_t;

  // index of the last step of a job
  function automatic logic [STEP_W-1:0] script_last(input job_kind_t k);
    logic [STEP_W-1:0] r;
    case (k)
      JOB_RESET:  r = STEP_W'(2);
      JOB_CONFIG: r = STEP_W'(3);
      JOB_ENABLE: r = STEP_W'(6);
      JOB_BANK:   r = STEP_W'(20);
      default:    r = '0;
    endcase
    return r;
  endfunction

  // {op, addr, data} of one scripted step
  function automatic logic [17:0] script_word(input job_kind_t k,
                                              input logic [STEP_W-1:0] s);
    logic [17:0] r;
    if (s == STEP_W'(0)) begin
      r = {OP_WRITE, REG_UNLOCK, UNLOCK_KEY};
    end else if (s == STEP_W'(1)) begin
      r = {OP_WRITE, REG_PAGE, PAGE_FUNC};
    end else begin
      case (k)
        JOB_RESET:  r = {OP_WRITE, REG_RESET, RESET_KEY};
        JOB_CONFIG: r = (s == STEP_W'(2)) ? {OP_WRITE, REG_CFG, CFG_INIT}
                                          : {OP_WRITE, REG_GCC, GCC_OFF};
        JOB_ENABLE: begin
          case (s)
            STEP_W'(2): r = {OP_WRITE, REG_PULL, PULL_VAL};
            STEP_W'(3): r = {OP_WRITE, REG_SPREAD, SPREAD_VAL};
            STEP_W'(4): r = {OP_WRITE, REG_GCC, GCC_FULL};
            STEP_W'(5): r = {OP_WRITE, REG_CFG, CFG_RUN};
            default:    r = {OP_READ, REG_CFG, 8'h00};
          endcase
        end
        default:    r = {OP_STATUS, 8'h00, 8'h00};
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lmrs_front.sv -----
// front end: accepts transactions, runs the power-up stage machine and issues jobs
`default_nettype none

module lmrs_front
  import lmrs_pkg::*;
#(
  parameter int unsigned NUM_BANKS = DEF_NUM_BANKS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] now_ms,
  input  wire logic        fault_n,
  input  wire logic        bus_ok,
  input  wire logic [7:0]  read_data,
  input  wire logic [7:0]  channel,
  input  wire logic [7:0]  value,
  input  wire dirty_fb_t   fb,
  output job_t             job
);

  localparam int unsigned NB = NUM_BANKS;

  stage_t            stage_r, stage_nxt;
  logic              req_r, req_nxt;
  logic              fault_r, fault_nxt;
  logic [31:0]       stamp_r, stamp_nxt;
  logic [7:0]        bright_r, bright_nxt;
  logic [BANK_W-1:0] cursor_r, cursor_nxt;
  logic [NB-1:0]     dirty_r, dirty_nxt;
  logic [1:0]        pend_r, pend_nxt;

  logic [15:0]       dirty16;
  logic [31:0]       elapsed;
  logic [BANK_W-1:0] cur_bank;
  logic [BANK_W:0]   cur_inc;
  logic [BANK_W:0]   cand;
  logic              found;
  logic [BANK_W-1:0] found_bank;
  logic              check_bad;

  assign dirty16 = 16'(dirty_r);
  assign elapsed = now_ms - stamp_r;
  assign cur_bank = ({1'b0, cursor_r} >= (BANK_W+1)'(NB)) ? '0 : cursor_r;
  assign cur_inc = {1'b0, cur_bank} + (BANK_W+1)'(1);
  assign check_bad = (pend_r != PEND_NONE) &&
                     (!bus_ok || (pend_r == PEND_READ && read_data != CFG_RUN));

  // round-robin search for the next dirty bank after the cursor
  always_comb begin
    found = 1'b0;
    found_bank = '0;
    cand = '0;
    for (int n = 1; n <= NB; n++) begin
      cand = {1'b0, cursor_r} + (BANK_W+1)'(n);
      if (cand >= (BANK_W+1)'(NB)) cand = cand - (BANK_W+1)'(NB);
      if (!found && dirty16[cand[BANK_W-1:0]]) begin
        found = 1'b1;
        found_bank = cand[BANK_W-1:0];
      end
    end
  end

  // next state and job for the accepted transaction
  always_comb begin
    stage_nxt  = stage_r;
    req_nxt    = req_r;
    fault_nxt  = fault_r;
    stamp_nxt  = stamp_r;
    bright_nxt = bright_r;
    cursor_nxt = cursor_r;
    pend_nxt   = pend_r;
    dirty_nxt  = dirty_r;
    if (fb.valid) begin
      for (int i = 0; i < NB; i++) begin
        if (BANK_W'(i) == fb.bank) dirty_nxt[i] = 1'b1;
      end
    end
    job.kind   = JOB_STATUS;
    job.bank   = '0;
    job.scale  = 1'b0;
    job.ch     = channel;
    job.val    = value;

    if (acc) begin
      case (kind)
        K_TICK: begin
          pend_nxt = PEND_NONE;
          if (req_r && !fault_r) begin
            if (check_bad || !fault_n) begin
              fault_nxt = 1'b1;
              stage_nxt = ST_OFF;
            end else begin
              case (stage_r)
                ST_WAIT: begin
                  if (elapsed >= WAIT_POWER_MS) stage_nxt = ST_RESET;
                end
                ST_RESET: begin
                  job.kind  = JOB_RESET;
                  stamp_nxt = now_ms;
                  stage_nxt = ST_CONFIG;
                  pend_nxt  = PEND_BATCH;
                end
                ST_CONFIG: begin
                  if (elapsed >= WAIT_RESET_MS) begin
                    job.kind   = JOB_CONFIG;
                    cursor_nxt = '0;
                    stage_nxt  = ST_PWM;
                    pend_nxt   = PEND_BATCH;
                  end
                end
                ST_PWM, ST_SCALE: begin
                  job.kind  = JOB_BANK;
                  job.bank  = cur_bank;
                  job.scale = (stage_r == ST_SCALE);
                  if (stage_r == ST_PWM) begin
                    for (int i = 0; i < NB; i++) begin
                      if (BANK_W'(i) == cur_bank) dirty_nxt[i] = 1'b0;
                    end
                  end
                  if (cur_inc >= (BANK_W+1)'(NB)) begin
                    cursor_nxt = '0;
                    stage_nxt  = (stage_r == ST_PWM) ? ST_SCALE : ST_ENABLE;
                  end else begin
                    cursor_nxt = cur_inc[BANK_W-1:0];
                  end
                  pend_nxt = PEND_BATCH;
                end
                ST_ENABLE: begin
                  job.kind  = JOB_ENABLE;
                  stage_nxt = ST_READY;
                  pend_nxt  = PEND_READ;
                end
                ST_READY: begin
                  if (found) begin
                    job.kind   = JOB_BANK;
                    job.bank   = found_bank;
                    cursor_nxt = found_bank;
                    for (int i = 0; i < NB; i++) begin
                      if (BANK_W'(i) == found_bank) dirty_nxt[i] = 1'b0;
                    end
                    pend_nxt = PEND_BATCH;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        K_PIXEL: begin
          job.kind = JOB_PIXEL;
        end
        K_BRIGHT: begin
          if (bright_r != value) begin
            bright_nxt = value;
            dirty_nxt  = '1;
          end
        end
        K_PWR_ON: begin
          if (!req_r) begin
            req_nxt    = 1'b1;
            fault_nxt  = 1'b0;
            cursor_nxt = '0;
            stamp_nxt  = now_ms;
            stage_nxt  = ST_WAIT;
            pend_nxt   = PEND_NONE;
          end
        end
        K_PWR_OFF: begin
          req_nxt   = 1'b0;
          fault_nxt = 1'b0;
          stage_nxt = ST_OFF;
          pend_nxt  = PEND_NONE;
        end
        default: ;
      endcase
    end

    job.bright          = bright_nxt;
    job.st.power_enable = (stage_nxt != ST_OFF);
    job.st.ready_res    = (stage_nxt == ST_READY) && !fault_nxt;
    job.st.faulted      = fault_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= ST_OFF;
      req_r    <= 1'b0;
      fault_r  <= 1'b0;
      stamp_r  <= '0;
      bright_r <= 8'd64;
      cursor_r <= '0;
      dirty_r  <= '0;
      pend_r   <= PEND_NONE;
    end else begin
      stage_r  <= stage_nxt;
      req_r    <= req_nxt;
      fault_r  <= fault_nxt;
      stamp_r  <= stamp_nxt;
      bright_r <= bright_nxt;
      cursor_r <= cursor_nxt;
      dirty_r  <= dirty_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lmrs_jobq.sv -----
// two-entry job queue between the front end and the bus sequencer
`default_nettype none

module lmrs_jobq
  import lmrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      q_valid,
  output job_t      q_job
);

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = ent_r[rp_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lmrs_back.sv -----
// bus sequencer: expands jobs into bus operations, holds the pixel store and scales pwm
`default_nettype none

module lmrs_back
  import lmrs_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS  = DEF_NUM_CHANNELS,
  parameter int unsigned USED_CHANNELS = DEF_USED_CHANNELS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  input  wire job_t job_i,
  output logic      job_pop,
  output logic      idle,
  output dirty_fb_t fb,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  localparam int unsigned NC    = NUM_CHANNELS;
  localparam int unsigned CW    = $clog2(NUM_CHANNELS);
  localparam int unsigned DEPTH = 4;

  typedef struct packed {
    res_t       res;
    logic       mul;
    logic       pix;
    logic       inrange;
    logic [7:0] ch;
    logic [7:0] val;
    logic [7:0] bright;
  } flight_t;

  // sequencer state
  logic              active_r;
  job_t              job_r;
  logic [STEP_W-1:0] step_r;

  // pixel store with valid bits
  logic [7:0]        mem [NC];
  logic [NC-1:0]     vld_r;
  logic [7:0]        rdata_r;
  logic              rvld_r;

  // pipeline
  flight_t           pa_r, pa_nxt;
  logic              va_r, vb_r;
  res_t              pb_r;
  logic              pb_mul_r;
  logic [15:0]       prod_r;

  // result queue
  res_t              fifo_r [DEPTH];
  logic [1:0]        wp_r, rp_r;
  logic [2:0]        cnt_r;

  logic              room, issue, pop, wr_pix;
  logic [7:0]        base, idx, rsel;
  logic [CW-1:0]     raddr;
  logic [17:0]       sw;
  logic [7:0]        pixel;
  logic [13:0]       bank_mul;
  logic [16:0]       qsum;
  res_t              push_res;

  assign room    = ({1'b0, cnt_r} + {3'b0, va_r} + {3'b0, vb_r}) < 4'(DEPTH);
  assign issue   = active_r && room;
  assign job_pop = !active_r && job_valid;
  assign idle    = !active_r && !va_r && !vb_r;
  assign base    = 8'(job_r.bank) * 8'(CH_PER_BANK);
  assign idx     = base + 8'(step_r) - 8'd3;
  assign sw      = script_word(job_r.kind, step_r);

  // build the next bus operation
  always_comb begin
    pa_nxt               = '0;
    pa_nxt.res.st        = job_r.st;
    pa_nxt.res.last      = (step_r == script_last(job_r.kind));
    pa_nxt.ch            = job_r.ch;
    pa_nxt.val           = job_r.val;
    pa_nxt.bright        = job_r.bright;
    pa_nxt.inrange       = ({1'b0, job_r.ch} < 9'(NC));
    pa_nxt.res.op        = sw[17:16];
    pa_nxt.res.addr      = sw[15:8];
    pa_nxt.res.data      = sw[7:0];
    rsel                 = idx;
    case (job_r.kind)
      JOB_STATUS: begin
        pa_nxt.res.op   = OP_STATUS;
        pa_nxt.res.addr = '0;
        pa_nxt.res.data = '0;
      end
      JOB_PIXEL: begin
        pa_nxt.res.op   = OP_STATUS;
        pa_nxt.res.addr = '0;
        pa_nxt.res.data = '0;
        pa_nxt.pix      = 1'b1;
        rsel            = job_r.ch;
      end
      JOB_BANK: begin
        if (step_r == STEP_W'(1)) begin
          pa_nxt.res.data = job_r.scale ? PAGE_SCALE : PAGE_PWM;
        end else if (step_r == STEP_W'(2)) begin
          pa_nxt.res.op   = OP_BURST;
          pa_nxt.res.addr = '0;
          pa_nxt.res.data = base + 8'd1;
        end else if (step_r != STEP_W'(0)) begin
          pa_nxt.res.op        = OP_BURST;
          pa_nxt.res.addr      = '0;
          pa_nxt.res.burst_end = pa_nxt.res.last;
          if (job_r.scale) begin
            pa_nxt.res.data = ({1'b0, idx} < 9'(USED_CHANNELS)) ? SCALE_FULL : 8'h00;
          end else begin
            pa_nxt.res.data = '0;
            pa_nxt.mul      = ({1'b0, idx} < 9'(NC));
          end
        end
      end
      default: ;
    endcase
    raddr = ({1'b0, rsel} < 9'(NC)) ? rsel[CW-1:0] : '0;
  end

  // job sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= '0;
    end else if (job_pop) begin
      active_r <= 1'b1;
      step_r   <= '0;
    end else if (issue) begin
      step_r <= step_r + STEP_W'(1);
      if (pa_nxt.res.last) active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) job_r <= job_i;
  end

  // pixel store read and pixel write check
  assign pixel    = rvld_r ? rdata_r : 8'h00;
  assign wr_pix   = va_r && pa_r.pix && pa_r.inrange && (pixel != pa_r.val);
  assign bank_mul = 14'(pa_r.ch) * 14'd57;
  assign fb.valid = wr_pix;
  assign fb.bank  = bank_mul[13:10];

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (wr_pix) mem[pa_r.ch[CW-1:0]] <= pa_r.val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      if (wr_pix) vld_r[pa_r.ch[CW-1:0]] <= 1'b1;
    end
  end

  // pipeline stages: store read, then multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= issue;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) pa_r <= pa_nxt;
    pb_r     <= pa_r.res;
    pb_mul_r <= pa_r.mul;
    prod_r   <= 16'(pixel) * 16'(pa_r.bright) + 16'd127;
  end

  // divide by 255 for values below 255 * 256 (quotient fits in 8 bits)
  assign qsum = 17'(prod_r) + 17'(prod_r[15:8]) + 17'd1;

  always_comb begin
    push_res = pb_r;
    if (pb_mul_r) push_res.data = qsum[15:8];
  end

  // result queue
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (vb_r) fifo_r[wp_r] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (vb_r) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, vb_r} - {2'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/led_matrix_refresh_sequencer.sv -----
// An accepted transaction's job goes through the job queue to the single bus sequencer, which
// emits one bus operation per cycle while the result queue has room, through a 2-stage store-read
// and multiply pipeline into the result queue; a new transaction is accepted only once the job
// queue is empty and the sequencer and pipeline are idle.
// Reset: synchronous active-low rst_n; the pixel store reads as zero until written.
`default_nettype none

module led_matrix_refresh_sequencer
  import lmrs_pkg::*;
#(
  parameter int unsigned NUM_BANKS     = DEF_NUM_BANKS,
  parameter int unsigned NUM_CHANNELS  = DEF_NUM_CHANNELS,
  parameter int unsigned USED_CHANNELS = DEF_USED_CHANNELS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // now_ms[31:0], fault_n[32], bus_ok[33], read_data[41:34], channel[49:42], value[57:50]
  input  wire logic [63:0] in_tdata,
  // kind[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // reg_addr[7:0], data[15:8], burst_end[16], power_enable[17], ready_res[18], faulted[19]
  output logic [23:0]      out_tdata,
  // op[1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  logic      acc, q_valid, job_pop, back_idle;
  job_t      job, q_job;
  dirty_fb_t fb;
  res_t      res;

  // one transaction at a time through the front end
  assign in_tready = !q_valid && back_idle;
  assign acc       = in_tvalid && in_tready;

  lmrs_front #(
    .NUM_BANKS (NUM_BANKS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .kind      (in_tuser),
    .now_ms    (in_tdata[31:0]),
    .fault_n   (in_tdata[32]),
    .bus_ok    (in_tdata[33]),
    .read_data (in_tdata[41:34]),
    .channel   (in_tdata[49:42]),
    .value     (in_tdata[57:50]),
    .fb        (fb),
    .job       (job)
  );

  lmrs_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc),
    .push_job (job),
    .pop      (job_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  lmrs_back #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .USED_CHANNELS (USED_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_i     (q_job),
    .job_pop   (job_pop),
    .idle      (back_idle),
    .fb        (fb),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // output packing
  assign out_tdata = {4'b0, res.st.faulted, res.st.ready_res, res.st.power_enable,
                      res.burst_end, res.data, res.addr};
  assign out_tuser = res.op;
  assign out_tlast = res.last;

  // a transaction blocks further input until its job has been taken and the sequencer is idle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_tready)
    else $error("input accepted while previous job still queued");

  // ready status never shows together with a latched fault
  a_ready_not_faulted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[18] && out_tdata[19]))
    else $error("ready and faulted both set");

  // ready status implies power is enabled
  a_ready_powered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[18]) |-> out_tdata[17])
    else $error("ready without power enable");

  // the job queue is never empty when the sequencer picks up a job
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> q_valid)
    else $error("job taken from empty queue");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench for the led matrix refresh sequencer
`default_nettype none

module testbench;
  import lmrs_pkg::*;

  localparam int NBANK = 11;
  localparam int NCHAN = 198;
  localparam int NUSED = 195;

  // predictor stage codes
  typedef enum logic [2:0] {
    P_OFF, P_WAIT, P_RESET, P_CONFIG, P_PWM, P_SCALE, P_ENABLE, P_READY
  } pstage_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_ms;
    logic        fault_n;
    logic        bus_ok;
    logic [7:0]  read_data;
    logic [7:0]  channel;
    logic [7:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] data;
    logic       burst_end;
    logic       power_enable;
    logic       ready_res;
    logic       faulted;
    logic       last;
  } busop_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // handshake seen at the last rising edge
  logic        in_tready_seen;

  cmd_t   cmd_queue[$];
  busop_t bus_ops_due[$];
  int     error_count;
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     stim_done;

  // sequencer model state
  pstage_t    m_stage;
  bit         m_requested;
  bit         m_fault;
  logic [31:0] m_stamp;
  logic [7:0] m_pixels[NCHAN];
  logic [7:0] m_bright;
  logic [3:0] m_cursor;
  bit         m_dirty[NBANK];
  logic [1:0] m_pending;
  busop_t     step_ops[$];

  // stimulus-side time and link behavior
  logic [31:0] clock_ms;

  led_matrix_refresh_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic push_op(input logic [1:0] op, input logic [7:0] a, input logic [7:0] d,
                         input logic e);
    busop_t r;
    r = '0;
    r.op = op;
    r.reg_addr = a;
    r.data = d;
    r.burst_end = e;
    step_ops.push_back(r);
  endtask

  task automatic push_page(input logic [7:0] p);
    push_op(OP_WRITE, REG_UNLOCK, UNLOCK_KEY, 1'b0);
    push_op(OP_WRITE, REG_PAGE, p, 1'b0);
  endtask

  task automatic push_bank(input int bank, input bit scale);
    int idx;
    logic [7:0] b;
    logic [15:0] prod;
    push_page(scale ? PAGE_SCALE : PAGE_PWM);
    push_op(OP_BURST, 8'h00, 8'(bank * CH_PER_BANK + 1), 1'b0);
    for (int i = 0; i < CH_PER_BANK; i++) begin
      idx = bank * CH_PER_BANK + i;
      if (scale) b = (idx < NUSED) ? SCALE_FULL : 8'h00;
      else if (idx < NCHAN) begin
        prod = m_pixels[idx] * m_bright + 16'd127;
        b = 8'(prod / 16'd255);
      end else b = 8'h00;
      push_op(OP_BURST, 8'h00, b, i == CH_PER_BANK - 1);
    end
  endtask

  task automatic latch_fault();
    m_fault = 1;
    m_stage = P_OFF;
    m_pending = PEND_NONE;
  endtask

  // one tick of the power-up and refresh sequence
  task automatic tick_model(input cmd_t c);
    logic [1:0] pc;
    pc = m_pending;
    m_pending = PEND_NONE;
    if (!m_requested || m_fault) return;
    if (pc != PEND_NONE && (!c.bus_ok || (pc == PEND_READ && c.read_data != CFG_RUN))) begin
      latch_fault();
      return;
    end
    if (!c.fault_n) begin
      latch_fault();
      return;
    end
    case (m_stage)
      P_WAIT: if (c.now_ms - m_stamp >= WAIT_POWER_MS) m_stage = P_RESET;
      P_RESET: begin
        push_page(PAGE_FUNC);
        push_op(OP_WRITE, REG_RESET, RESET_KEY, 1'b0);
        m_stamp = c.now_ms;
        m_stage = P_CONFIG;
        m_pending = PEND_BATCH;
      end
      P_CONFIG: begin
        if (c.now_ms - m_stamp >= WAIT_RESET_MS) begin
          push_page(PAGE_FUNC);
          push_op(OP_WRITE, REG_CFG, CFG_INIT, 1'b0);
          push_op(OP_WRITE, REG_GCC, GCC_OFF, 1'b0);
          m_cursor = 0;
          m_stage = P_PWM;
          m_pending = PEND_BATCH;
        end
      end
      P_PWM, P_SCALE: begin
        if (m_cursor >= NBANK) m_cursor = 0;
        push_bank(m_cursor, m_stage == P_SCALE);
        if (m_stage == P_PWM) m_dirty[m_cursor] = 0;
        m_cursor++;
        if (m_cursor >= NBANK) begin
          m_cursor = 0;
          m_stage = (m_stage == P_PWM) ? P_SCALE : P_ENABLE;
        end
        m_pending = PEND_BATCH;
      end
      P_ENABLE: begin
        push_page(PAGE_FUNC);
        push_op(OP_WRITE, REG_PULL, PULL_VAL, 1'b0);
        push_op(OP_WRITE, REG_SPREAD, SPREAD_VAL, 1'b0);
        push_op(OP_WRITE, REG_GCC, GCC_FULL, 1'b0);
        push_op(OP_WRITE, REG_CFG, CFG_RUN, 1'b0);
        push_op(OP_READ, REG_CFG, 8'h00, 1'b0);
        m_stage = P_READY;
        m_pending = PEND_READ;
      end
      P_READY: begin
        for (int n = 0; n < NBANK; n++) begin
          m_cursor = 4'((m_cursor + 1) % NBANK);
          if (m_dirty[m_cursor]) begin
            push_bank(m_cursor, 1'b0);
            m_dirty[m_cursor] = 0;
            m_pending = PEND_BATCH;
            break;
          end
        end
      end
      default: ;
    endcase
  endtask

  // predict all bus operations caused by one command
  task automatic predict_command(input cmd_t c);
    busop_t r;
    step_ops.delete();
    case (c.kind)
      K_TICK: tick_model(c);
      K_PIXEL: begin
        if (c.channel < NCHAN && m_pixels[c.channel] != c.value) begin
          m_pixels[c.channel] = c.value;
          if (c.channel / CH_PER_BANK < NBANK) m_dirty[c.channel / CH_PER_BANK] = 1;
        end
      end
      K_BRIGHT: begin
        if (m_bright != c.value) begin
          m_bright = c.value;
          for (int i = 0; i < NBANK; i++) m_dirty[i] = 1;
        end
      end
      K_PWR_ON: begin
        if (!m_requested) begin
          m_requested = 1;
          m_fault = 0;
          m_cursor = 0;
          m_stamp = c.now_ms;
          m_stage = P_WAIT;
          m_pending = PEND_NONE;
        end
      end
      K_PWR_OFF: begin
        m_requested = 0;
        m_fault = 0;
        m_stage = P_OFF;
        m_pending = PEND_NONE;
      end
      default: ;
    endcase
    if (step_ops.size() == 0) push_op(OP_STATUS, 8'h00, 8'h00, 1'b0);
    foreach (step_ops[k]) begin
      r = step_ops[k];
      r.power_enable = (m_stage != P_OFF);
      r.ready_res = (m_stage == P_READY) && !m_fault;
      r.faulted = m_fault;
      r.last = (k == step_ops.size() - 1);
      bus_ops_due.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // driver: present commands at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready_seen) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_t c;
          c = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= c.kind;
          in_tdata <= {6'd0, c.value, c.channel, c.read_data, c.bus_ok, c.fault_n, c.now_ms};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // record accepted commands and predict their results
  always @(posedge clk) begin
    in_tready_seen <= 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      in_tready_seen <= 1'b1;
      predict_command(cmd_t'{in_tuser, in_tdata[31:0], in_tdata[32], in_tdata[33],
                             in_tdata[41:34], in_tdata[49:42], in_tdata[57:50]});
    end
  end

  // monitor: compare each bus operation with the oldest prediction
  always @(posedge clk) begin
    busop_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (bus_ops_due.size() == 0) begin
        report_mismatch("unexpected transaction", {out_tuser, out_tdata}, 0);
      end else begin
        w = bus_ops_due.pop_front();
        if (out_tuser != w.op) report_mismatch("op", out_tuser, w.op);
        if (out_tdata[7:0] != w.reg_addr) report_mismatch("reg_addr", out_tdata[7:0], w.reg_addr);
        if (out_tdata[15:8] != w.data) report_mismatch("data", out_tdata[15:8], w.data);
        if (out_tdata[16] != w.burst_end) report_mismatch("burst_end", out_tdata[16], w.burst_end);
        if (out_tdata[17] != w.power_enable)
          report_mismatch("power_enable", out_tdata[17], w.power_enable);
        if (out_tdata[18] != w.ready_res) report_mismatch("ready_res", out_tdata[18], w.ready_res);
        if (out_tdata[19] != w.faulted) report_mismatch("faulted", out_tdata[19], w.faulted);
        if (out_tlast != w.last) report_mismatch("last", out_tlast, w.last);
      end
    end
  end

  function automatic cmd_t make_cmd(input logic [2:0] kind, input logic [7:0] ch,
                                    input logic [7:0] val);
    cmd_t c;
    c.kind = kind;
    c.now_ms = clock_ms;
    c.fault_n = 1'b1;
    c.bus_ok = 1'b1;
    c.read_data = CFG_RUN;
    c.channel = ch;
    c.value = val;
    return c;
  endfunction

  // tick that advances time by the given milliseconds
  function automatic cmd_t tick_cmd(input logic [31:0] step_ms);
    clock_ms = clock_ms + step_ms;
    return make_cmd(K_TICK, 8'h00, 8'h00);
  endfunction

  // one full power-up sequence with random pixel traffic mixed in
  task automatic queue_bringup(input int extra_ticks);
    cmd_queue.push_back(make_cmd(K_PWR_ON, 8'h00, 8'h00));
    cmd_queue.push_back(tick_cmd(32'd5));
    cmd_queue.push_back(tick_cmd(32'd20));
    cmd_queue.push_back(tick_cmd(32'd1));
    cmd_queue.push_back(tick_cmd(32'd1));
    cmd_queue.push_back(tick_cmd(32'd2));
    for (int i = 0; i < 2 * NBANK + 1 + extra_ticks; i++) begin
      if ($urandom_range(3) == 0)
        cmd_queue.push_back(make_cmd(K_PIXEL, 8'($urandom_range(NCHAN - 1)), 8'($urandom)));
      cmd_queue.push_back(tick_cmd(32'($urandom_range(3))));
    end
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_tvalid || bus_ops_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    cmd_t c;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    clock_ms = 32'hffff_fff0;
    m_stage = P_OFF;
    m_requested = 0;
    m_fault = 0;
    m_stamp = '0;
    m_bright = 8'd64;
    m_cursor = '0;
    m_pending = PEND_NONE;
    foreach (m_pixels[i]) m_pixels[i] = '0;
    foreach (m_dirty[i]) m_dirty[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: idle tick, unknown kinds, field extremes, pixel edge channels
    cmd_queue.push_back(tick_cmd(32'd0));
    for (int k = 5; k < 8; k++) cmd_queue.push_back(make_cmd(3'(k), 8'hff, 8'hff));
    cmd_queue.push_back(make_cmd(K_PIXEL, 8'd0, 8'hff));
    cmd_queue.push_back(make_cmd(K_PIXEL, 8'd197, 8'hff));
    cmd_queue.push_back(make_cmd(K_PIXEL, 8'd198, 8'h55));
    cmd_queue.push_back(make_cmd(K_PIXEL, 8'd255, 8'haa));
    cmd_queue.push_back(make_cmd(K_BRIGHT, 8'h00, 8'hff));
    // power-up across the time wrap, repeated power on, then ready refresh
    queue_bringup(3);
    cmd_queue.push_back(make_cmd(K_PWR_ON, 8'h00, 8'h00));
    cmd_queue.push_back(make_cmd(K_BRIGHT, 8'h00, 8'h00));
    cmd_queue.push_back(tick_cmd(32'd1));
    cmd_queue.push_back(make_cmd(K_BRIGHT, 8'h00, 8'h80));
    wait_drained();

    // random phases with different idling, continuing from the ready state
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 68 : 21) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 68 : 21) : 0;
      for (int i = 0; i < 14; i++) begin
        c = make_cmd(3'($urandom_range(7)), 8'($urandom), 8'($urandom));
        if ($urandom_range(3) != 0) c = make_cmd($urandom_range(1) ? K_TICK : K_PIXEL,
                                                 8'($urandom), 8'($urandom));
        c.now_ms = $urandom_range(1) ? clock_ms + $urandom_range(30) : $urandom;
        c.fault_n = ($urandom_range(15) != 0);
        c.bus_ok = ($urandom_range(15) != 0);
        c.read_data = $urandom_range(1) ? CFG_RUN : 8'($urandom);
        cmd_queue.push_back(c);
      end
      wait_drained();
    end
    cmd_queue.push_back(make_cmd(K_PWR_OFF, 8'h00, 8'h00));
    wait_drained();
    stim_done = 1;
  end

  // final verdict
  initial begin
    wait (stim_done);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/lmrs_pkg.sv
hw/rtl/lmrs_front.sv
hw/rtl/lmrs_jobq.sv
hw/rtl/lmrs_back.sv
hw/rtl/led_matrix_refresh_sequencer.sv
bench/testbench.sv
